/* rtl/alarm_pattern_sequencer_macros.svh */
// Assertion helpers for the alarm pattern sequencer checker.
`ifndef ALARM_PATTERN_SEQUENCER_MACROS_SVH
`define ALARM_PATTERN_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define APS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define APS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

/* rtl/aps_pkg.sv */
package aps_pkg;

    localparam int unsigned MS_W   = 16;
    localparam int unsigned RPT_W  = 4;
    localparam int unsigned SETL_W = 8;
    localparam int unsigned REQ_W  = 4;
    localparam int unsigned IDX_W  = 3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_SHORT_ON   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_LONG_ON    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_PULSE_GAP  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_LETTER_GAP = 3'd3;
    localparam logic [IDX_W-1:0] CFG_BEEP       = 3'd4;
    localparam logic [IDX_W-1:0] CFG_ALARM_HALF = 3'd5;
    localparam logic [IDX_W-1:0] CFG_REPEAT     = 3'd6;
    localparam logic [IDX_W-1:0] CFG_SETTLE     = 3'd7;

    // Request bits of trigger_mask
    localparam int unsigned REQ_SOS  = 0;
    localparam int unsigned REQ_BEEP = 1;
    localparam int unsigned REQ_LED  = 2;
    localparam int unsigned REQ_ACOU = 3;

    localparam logic [RPT_W-1:0] PULSE_MAX  = 4'd15;
    localparam logic [1:0]       LETTER_MAX = 2'd2;
    localparam logic [1:0]       LETTER_LONG = 2'd1;

    typedef enum logic [4:0] {
        PH_SETTLE = 5'b00001,
        PH_IDLE   = 5'b00010,
        PH_ON     = 5'b00100,
        PH_OFF    = 5'b01000,
        PH_GAP    = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        PAT_SOS  = 2'd0,
        PAT_BEEP = 2'd1,
        PAT_ACOU = 2'd2,
        PAT_LED  = 2'd3
    } t_pattern;

    typedef struct packed {
        logic [MS_W-1:0]   short_on_ms;
        logic [MS_W-1:0]   long_on_ms;
        logic [MS_W-1:0]   pulse_gap_ms;
        logic [MS_W-1:0]   letter_gap_ms;
        logic [MS_W-1:0]   beep_ms;
        logic [MS_W-1:0]   alarm_half_ms;
        logic [RPT_W-1:0]  repeat_count;
        logic [SETL_W-1:0] settle_ms;
    } t_cfg;

    typedef struct packed {
        logic busy_res;
        logic led_pin;
        logic buzzer_pin;
    } t_pins;

endpackage

/* rtl/alarm_pattern_sequencer.sv */
// Alarm pattern sequencer: each input item carries a millisecond tick flag and a
// mask of trigger requests; each accepted item produces exactly one result item
// with the buzzer pin level (active low), the LED pin level and a busy flag,
// taken after that item's state update. The block accepts one item every clock
// cycle unless a result is stalled; each result is registered on acceptance, and
// a new item is taken while a result waits whenever the output side is ready in
// that cycle. Pattern state advances in one pass of counter and compare logic
// per item. Configuration writes are taken in any cycle and are meant for idle
// periods; register index i of the cfg port selects register i of the list.
module alarm_pattern_sequencer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // tdata: [0] tick, [4:1] trigger_mask, [7:5] zero
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,
    // tdata: [0] buzzer_pin, [1] led_pin, [2] busy_res, [7:3] zero
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [aps_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [aps_pkg::MS_W-1:0]  i_cfg_data
);
    import aps_pkg::*;

    t_cfg  cfg;
    t_pins pins;
    logic  accept;
    logic  r_out_valid;
    t_pins r_out;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    aps_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    aps_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (accept),
        .i_tick         (s_axis_tdata[0]),
        .i_trigger_mask (s_axis_tdata[REQ_W:1]),
        .i_cfg          (cfg),
        .o_pins         (pins)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= pins;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.busy_res, r_out.led_pin, r_out.buzzer_pin};

endmodule

/* rtl/aps_cfg_regs.sv */
module aps_cfg_regs (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [aps_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [aps_pkg::MS_W-1:0]  i_cfg_data,
    output aps_pkg::t_cfg           o_cfg
);
    import aps_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_on_ms   <= 16'd100;
            r_cfg.long_on_ms    <= 16'd300;
            r_cfg.pulse_gap_ms  <= 16'd100;
            r_cfg.letter_gap_ms <= 16'd200;
            r_cfg.beep_ms       <= 16'd100;
            r_cfg.alarm_half_ms <= 16'd200;
            r_cfg.repeat_count  <= 4'd3;
            r_cfg.settle_ms     <= 8'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SHORT_ON:   r_cfg.short_on_ms   <= i_cfg_data;
                CFG_LONG_ON:    r_cfg.long_on_ms    <= i_cfg_data;
                CFG_PULSE_GAP:  r_cfg.pulse_gap_ms  <= i_cfg_data;
                CFG_LETTER_GAP: r_cfg.letter_gap_ms <= i_cfg_data;
                CFG_BEEP:       r_cfg.beep_ms       <= i_cfg_data;
                CFG_ALARM_HALF: r_cfg.alarm_half_ms <= i_cfg_data;
                CFG_REPEAT:     r_cfg.repeat_count  <= i_cfg_data[RPT_W-1:0];
                CFG_SETTLE:     r_cfg.settle_ms     <= i_cfg_data[SETL_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

/* rtl/aps_seq.sv */
module aps_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_tick,
    input  logic [aps_pkg::REQ_W-1:0] i_trigger_mask,
    input  aps_pkg::t_cfg             i_cfg,
    output aps_pkg::t_pins            o_pins
);
    import aps_pkg::*;

    logic [REQ_W-1:0] r_pend,   n_pend;
    t_phase           r_phase,  n_phase;
    t_pattern         r_pat,    n_pat;
    logic [MS_W-1:0]  r_ms,     n_ms;
    logic [RPT_W-1:0] r_pulse,  n_pulse;
    logic [1:0]       r_letter, n_letter;

    logic [MS_W-1:0]  ms_inc;
    logic [MS_W-1:0]  on_time;
    logic [MS_W-1:0]  off_time;
    logic [RPT_W-1:0] pulse_inc;
    logic [RPT_W-1:0] rpt_eff;
    logic [REQ_W-1:0] pend_or;
    logic             is_on;

    assign ms_inc    = (r_ms == '1) ? r_ms : r_ms + 1'b1;
    assign pulse_inc = (r_pulse < PULSE_MAX) ? r_pulse + 1'b1 : r_pulse;
    assign rpt_eff   = (i_cfg.repeat_count == '0) ? RPT_W'(1) : i_cfg.repeat_count;
    assign pend_or   = r_pend | i_trigger_mask;

    always_comb begin
        priority if (r_pat == PAT_SOS) begin
            on_time = (r_letter == LETTER_LONG) ? i_cfg.long_on_ms : i_cfg.short_on_ms;
        end else if (r_pat == PAT_BEEP) begin
            on_time = i_cfg.beep_ms;
        end else begin
            on_time = i_cfg.alarm_half_ms;
        end
        off_time = (r_pat == PAT_SOS) ? i_cfg.pulse_gap_ms : i_cfg.alarm_half_ms;
    end

    always_comb begin
        n_pend   = pend_or;
        n_phase  = r_phase;
        n_pat    = r_pat;
        n_ms     = r_ms;
        n_pulse  = r_pulse;
        n_letter = r_letter;

        unique case (r_phase)
            PH_SETTLE: begin
                if (i_tick && (r_ms < MS_W'(i_cfg.settle_ms))) begin
                    n_ms = r_ms + 1'b1;
                end
                if (n_ms >= MS_W'(i_cfg.settle_ms)) begin
                    n_phase = PH_IDLE;
                    n_ms    = '0;
                end
            end
            PH_IDLE: ;
            PH_ON: begin
                if (i_tick) begin
                    n_ms = ms_inc;
                    if (ms_inc >= on_time) begin
                        n_ms    = '0;
                        n_phase = (r_pat == PAT_BEEP) ? PH_SETTLE : PH_OFF;
                    end
                end
            end
            PH_OFF: begin
                if (i_tick) begin
                    n_ms = ms_inc;
                    if (ms_inc >= off_time) begin
                        n_ms    = '0;
                        n_pulse = pulse_inc;
                        priority if (pulse_inc < rpt_eff) begin
                            n_phase = PH_ON;
                        end else if (r_pat == PAT_SOS && r_letter < LETTER_MAX) begin
                            if (i_cfg.letter_gap_ms == '0) begin
                                n_letter = r_letter + 1'b1;
                                n_pulse  = '0;
                                n_phase  = PH_ON;
                            end else begin
                                n_phase = PH_GAP;
                            end
                        end else begin
                            n_phase = PH_SETTLE;
                        end
                    end
                end
            end
            PH_GAP: begin
                if (i_tick) begin
                    n_ms = ms_inc;
                    if (ms_inc >= i_cfg.letter_gap_ms) begin
                        if (r_letter < LETTER_MAX) begin
                            n_letter = r_letter + 1'b1;
                        end
                        n_pulse = '0;
                        n_ms    = '0;
                        n_phase = PH_ON;
                    end
                end
            end
            default: ;
        endcase

        // idle reached in this item starts the request at once
        if (n_phase == PH_IDLE && pend_or != '0) begin
            priority if (pend_or[REQ_SOS]) begin
                n_pat = PAT_SOS;
            end else if (pend_or[REQ_BEEP]) begin
                n_pat = PAT_BEEP;
            end else if (pend_or[REQ_ACOU]) begin
                n_pat = PAT_ACOU;
            end else begin
                n_pat = PAT_LED;
            end
            n_pend   = '0;
            n_letter = '0;
            n_pulse  = '0;
            n_ms     = '0;
            n_phase  = PH_ON;
        end
    end

    assign is_on             = (n_phase == PH_ON);
    assign o_pins.buzzer_pin = !(is_on && n_pat != PAT_LED);
    assign o_pins.led_pin    = is_on && n_pat != PAT_BEEP;
    assign o_pins.busy_res   = (n_phase != PH_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= '0;
            r_phase  <= PH_SETTLE;
            r_pat    <= PAT_SOS;
            r_ms     <= '0;
            r_pulse  <= '0;
            r_letter <= '0;
        end else if (i_en) begin
            r_pend   <= n_pend;
            r_phase  <= n_phase;
            r_pat    <= n_pat;
            r_ms     <= n_ms;
            r_pulse  <= n_pulse;
            r_letter <= n_letter;
        end
    end

endmodule

/* rtl/aps_checker.sv */
`include "alarm_pattern_sequencer_macros.svh"

module aps_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // a sounding buzzer means a pattern is running
    `APS_ASSERT_NOW(a_buzz_busy, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[2])

    // a lit LED means a pattern is running
    `APS_ASSERT_NOW(a_led_busy, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[2])

    // an empty output register never blocks the input side
    `APS_ASSERT_NOW(a_ready_empty, !m_axis_tvalid, s_axis_tready)

    // a stalled result holds
    `APS_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind alarm_pattern_sequencer aps_checker u_aps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* sim/tb_alarm_pattern_sequencer.sv */
module tb_alarm_pattern_sequencer;
    import aps_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [IDX_W-1:0]      i_cfg_index = '0;
    logic [MS_W-1:0]       i_cfg_data = '0;

    alarm_pattern_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // items waiting to be sent: [0] tick, [4:1] trigger_mask
    logic [7:0] items_todo[$];
    t_pins      pins_due[$];

    int n_errs = 0;
    int n_items_in = 0;
    int n_results = 0;
    int n_writes = 0;
    int n_settings = 0;
    int idle_cycles = 0;

    // mirror of the sequencer
    t_cfg       cfg_m;
    t_phase     ph_m;
    t_pattern   pat_m;
    logic [3:0] pend_m;
    logic [15:0] ms_m;
    logic [3:0] pulse_m;
    logic [1:0] letter_m;
    int         starts[4];

    function automatic void go_phase(input t_phase p);
        ph_m = p;
        ms_m = '0;
    endfunction

    function automatic logic ms_reached(input logic [15:0] dur);
        if (ms_m != 16'hFFFF)
            ms_m++;
        return ms_m >= dur;
    endfunction

    function automatic void mirror_reset();
        cfg_m.short_on_ms   = 16'd100;
        cfg_m.long_on_ms    = 16'd300;
        cfg_m.pulse_gap_ms  = 16'd100;
        cfg_m.letter_gap_ms = 16'd200;
        cfg_m.beep_ms       = 16'd100;
        cfg_m.alarm_half_ms = 16'd200;
        cfg_m.repeat_count  = 4'd3;
        cfg_m.settle_ms     = 8'd1;
        pend_m   = '0;
        pat_m    = PAT_SOS;
        pulse_m  = '0;
        letter_m = '0;
        go_phase(PH_SETTLE);
    endfunction

    function automatic void mirror_write(input logic [IDX_W-1:0] idx, input logic [15:0] val);
        case (idx)
            CFG_SHORT_ON:   cfg_m.short_on_ms = val;
            CFG_LONG_ON:    cfg_m.long_on_ms = val;
            CFG_PULSE_GAP:  cfg_m.pulse_gap_ms = val;
            CFG_LETTER_GAP: cfg_m.letter_gap_ms = val;
            CFG_BEEP:       cfg_m.beep_ms = val;
            CFG_ALARM_HALF: cfg_m.alarm_half_ms = val;
            CFG_REPEAT:     cfg_m.repeat_count = val[3:0];
            CFG_SETTLE:     cfg_m.settle_ms = val[7:0];
            default: ;
        endcase
    endfunction

    // advances the mirror by one item and returns the pin levels after it
    function automatic t_pins predict_pins(input logic tick, input logic [3:0] trig);
        logic [3:0]  reps;
        logic [15:0] dur;
        logic        on;
        t_pins       pins;
        pend_m = pend_m | trig;
        case (ph_m)
            PH_SETTLE: begin
                if (tick && ms_m < {8'd0, cfg_m.settle_ms})
                    ms_m++;
                if (ms_m >= {8'd0, cfg_m.settle_ms})
                    go_phase(PH_IDLE);
            end
            PH_ON: begin
                if (pat_m == PAT_SOS)
                    dur = (letter_m == LETTER_LONG) ? cfg_m.long_on_ms : cfg_m.short_on_ms;
                else if (pat_m == PAT_BEEP)
                    dur = cfg_m.beep_ms;
                else
                    dur = cfg_m.alarm_half_ms;
                if (tick && ms_reached(dur)) begin
                    if (pat_m == PAT_BEEP)
                        go_phase(PH_SETTLE);
                    else
                        go_phase(PH_OFF);
                end
            end
            PH_OFF: begin
                dur = (pat_m == PAT_SOS) ? cfg_m.pulse_gap_ms : cfg_m.alarm_half_ms;
                if (tick && ms_reached(dur)) begin
                    if (pulse_m != PULSE_MAX)
                        pulse_m++;
                    reps = (cfg_m.repeat_count == 0) ? 4'd1 : cfg_m.repeat_count;
                    if (pulse_m < reps) begin
                        go_phase(PH_ON);
                    end else if (pat_m == PAT_SOS && letter_m < LETTER_MAX) begin
                        // no letter gap: next letter starts right away
                        if (cfg_m.letter_gap_ms == 0) begin
                            letter_m++;
                            pulse_m = '0;
                            go_phase(PH_ON);
                        end else begin
                            go_phase(PH_GAP);
                        end
                    end else begin
                        go_phase(PH_SETTLE);
                    end
                end
            end
            PH_GAP: begin
                if (tick && ms_reached(cfg_m.letter_gap_ms)) begin
                    if (letter_m < LETTER_MAX)
                        letter_m++;
                    pulse_m = '0;
                    go_phase(PH_ON);
                end
            end
            default: ;
        endcase

        // idle picks up a pending request within the same item
        if (ph_m == PH_IDLE && pend_m != 0) begin
            if (pend_m[REQ_SOS])
                pat_m = PAT_SOS;
            else if (pend_m[REQ_BEEP])
                pat_m = PAT_BEEP;
            else if (pend_m[REQ_ACOU])
                pat_m = PAT_ACOU;
            else
                pat_m = PAT_LED;
            starts[pat_m]++;
            pend_m   = '0;
            letter_m = '0;
            pulse_m  = '0;
            go_phase(PH_ON);
        end

        on = (ph_m == PH_ON);
        pins.buzzer_pin = !(on && pat_m != PAT_LED);
        pins.led_pin    = on && pat_m != PAT_BEEP;
        pins.busy_res   = (ph_m != PH_IDLE);
        return pins;
    endfunction

    // sender: bursts of random length with random gaps
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        logic       offer;
        logic [7:0] next_data;
        t_pins      due;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                due = predict_pins(s_axis_tdata[0], s_axis_tdata[4:1]);
                pins_due.push_back(due);
                void'(items_todo.pop_front());
                n_items_in++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                offer = 1'b0;
                next_data = s_axis_tdata;
                if (gap_left != 0) begin
                    gap_left--;
                end else if (items_todo.size() != 0) begin
                    offer = 1'b1;
                    next_data = items_todo[0];
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end
                s_axis_tvalid <= offer;
                s_axis_tdata  <= next_data;
            end
        end
    end

    // receiver: stall pattern in modes, plus one long hold to back up the input
    int rx_mode = 0;
    int rx_left = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;

    always @(posedge i_clk) begin
        logic rdy;
        if (hold_left != 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (!hold_done && n_results >= 500 && items_todo.size() > 40) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rdy = 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(8, 80);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                0: rdy = 1'b1;
                1: rdy = 1'($urandom_range(0, 1));
                2: rdy = ($urandom_range(0, 3) == 0);
                default: rdy = !m_axis_tready;
            endcase
        end
        m_axis_tready <= rdy;
    end

    always @(posedge i_clk) begin
        t_pins want;
        t_pins got;
        if (m_axis_tvalid && m_axis_tready) begin
            n_results++;
            got = t_pins'(m_axis_tdata[2:0]);
            if (pins_due.size() == 0) begin
                $error("result item with no expectation: tdata %02h", m_axis_tdata);
                n_errs++;
            end else begin
                want = pins_due.pop_front();
                if (got.buzzer_pin !== want.buzzer_pin) begin
                    $error("buzzer_pin: expected %0b, got %0b", want.buzzer_pin, got.buzzer_pin);
                    n_errs++;
                end
                if (got.led_pin !== want.led_pin) begin
                    $error("led_pin: expected %0b, got %0b", want.led_pin, got.led_pin);
                    n_errs++;
                end
                if (got.busy_res !== want.busy_res) begin
                    $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
                    n_errs++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_item(input logic tick, input logic [3:0] trig);
        items_todo.push_back({3'b000, trig, tick});
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_item(1'b1, 4'h0);
    endtask

    task automatic push_random(input int n);
        logic       tick;
        logic [3:0] trig;
        repeat (n) begin
            tick = ($urandom_range(0, 99) < 75);
            trig = ($urandom_range(0, 99) < 8) ? 4'($urandom_range(1, 15)) : 4'h0;
            push_item(tick, trig);
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (items_todo.size() != 0 || pins_due.size() != 0);
    endtask

    // leaves i_cfg_valid high so back-to-back writes follow without a gap
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready));
        mirror_write(idx, val);
        n_writes++;
    endtask

    task automatic load_setting(input t_cfg c);
        logic [31:0] pad;
        pad = $urandom;
        write_reg(CFG_SHORT_ON,   c.short_on_ms);
        write_reg(CFG_LONG_ON,    c.long_on_ms);
        write_reg(CFG_PULSE_GAP,  c.pulse_gap_ms);
        write_reg(CFG_LETTER_GAP, c.letter_gap_ms);
        write_reg(CFG_BEEP,       c.beep_ms);
        write_reg(CFG_ALARM_HALF, c.alarm_half_ms);
        // unused upper data bits carry noise
        write_reg(CFG_REPEAT,     {pad[11:0], c.repeat_count});
        write_reg(CFG_SETTLE,     {pad[31:24], c.settle_ms});
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    function automatic t_cfg short_setting();
        t_cfg c;
        c.short_on_ms   = 16'($urandom_range(0, 4));
        c.long_on_ms    = 16'($urandom_range(0, 4));
        c.pulse_gap_ms  = 16'($urandom_range(0, 4));
        c.letter_gap_ms = 16'($urandom_range(0, 4));
        c.beep_ms       = 16'($urandom_range(0, 4));
        c.alarm_half_ms = 16'($urandom_range(0, 4));
        c.repeat_count  = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(5, 15))
                                                      : 4'($urandom_range(0, 4));
        c.settle_ms     = 8'($urandom_range(0, 3));
        return c;
    endfunction

    initial begin
        t_cfg c;
        mirror_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: settle after one tick, then an SOS request
        push_item(1'b0, 4'h0);
        push_item(1'b1, 4'h0);
        push_item(1'b0, 4'h0);
        push_item(1'b0, 4'h1);
        push_ticks(2);
        wait_drained();

        // all registers zero: durations act as 1 ms, one pulse, no letter gap,
        // no settle; the running SOS sees the new values at once
        load_setting('0);
        push_item(1'b1, 4'hF);
        push_item(1'b0, 4'h0);
        push_item(1'b1, 4'hE);
        push_ticks(7);
        push_item(1'b0, 4'h8);
        push_ticks(3);
        push_item(1'b0, 4'h4);
        push_ticks(3);
        push_item(1'b1, 4'hC);
        push_ticks(3);
        wait_drained();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                3: c = '1;
                7: begin
                    c.short_on_ms   = 16'($urandom);
                    c.long_on_ms    = 16'($urandom);
                    c.pulse_gap_ms  = 16'($urandom);
                    c.letter_gap_ms = 16'($urandom);
                    c.beep_ms       = 16'($urandom);
                    c.alarm_half_ms = 16'($urandom);
                    c.repeat_count  = 4'($urandom);
                    c.settle_ms     = 8'($urandom);
                end
                default: c = short_setting();
            endcase
            load_setting(c);
            push_random((ph == 3 || ph == 7) ? 30 : 130);
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        $display("%0d items, %0d results, %0d register writes over %0d settings",
                 n_items_in, n_results, n_writes, n_settings);
        $display("patterns started: sos %0d, beep %0d, acoustic %0d, led %0d",
                 starts[PAT_SOS], starts[PAT_BEEP], starts[PAT_ACOU], starts[PAT_LED]);
        if (n_errs == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
